[src/e2c_pkg.sv]
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared widths, constants and calendar helpers for the epoch converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int EPOCH_BITS_DEF = 32;

  // seconds remainder width: holds anything below three 400-year cycles
  localparam int REM_BITS  = 36;
  localparam int YEAR_BITS = 12;

  typedef logic [REM_BITS-1:0] rem_t;

  // seconds in one 400-year cycle of 146097 days
  localparam rem_t CYCLE_SECS = 36'd12622780800;
  // floor(2^64 / CYCLE_SECS), scales the upper 32 epoch bits to a cycle count
  localparam logic [30:0] CYCLE_RECIP =
    31'(64'hFFFF_FFFF_FFFF_FFFF / 64'd12622780800);
  // CYCLE_SECS / 128
  localparam logic [30:0] CYCLE_SECS_DIV128 = 31'd98615475;

  localparam rem_t YEAR_SECS      = 36'd31536000;
  localparam rem_t LEAP_YEAR_SECS = 36'd31622400;
  localparam rem_t DAY_SECS       = 36'd86400;
  localparam rem_t HOUR_SECS      = 36'd3600;
  localparam rem_t MINUTE_SECS    = 36'd60;

  localparam logic [YEAR_BITS-1:0] EPOCH_YEAR  = 12'd1970;
  localparam logic [YEAR_BITS-1:0] CYCLE_YEARS = 12'd400;
  // 1970 mod 400
  localparam logic [8:0] EPOCH_YEAR_MOD400     = 9'd370;

  // year mod 400 -> leap
  function automatic logic is_leap(input logic [8:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  // seconds in month, month coded 1..12
  function automatic rem_t month_secs(input logic [3:0] mon, input logic leap);
    rem_t s;
    case (mon)
      4'd2:                    s = leap ? 36'd2505600 : 36'd2419200;
      4'd4, 4'd6, 4'd9, 4'd11: s = 36'd2592000;
      default:                 s = 36'd2678400;
    endcase
    return s;
  endfunction

endpackage

[src/e2c_sub.sv]
// ----------------------------------------------------------------------------
// e2c_sub
// Shared subtract/compare unit: diff = a - b with borrow (a < b).
// ----------------------------------------------------------------------------
module e2c_sub (
  input  logic [e2c_pkg::REM_BITS-1:0] a,
  input  logic [e2c_pkg::REM_BITS-1:0] b,
  output logic [e2c_pkg::REM_BITS-1:0] diff,
  output logic                         borrow
);

  logic [e2c_pkg::REM_BITS:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign borrow = full[e2c_pkg::REM_BITS];
  assign diff   = full[e2c_pkg::REM_BITS-1:0];

endmodule

[src/epoch_to_calendar_datetime.sv]
// ----------------------------------------------------------------------------
// epoch_to_calendar_datetime
// Seconds since 1970-01-01 00:00:00 UTC to UTC calendar date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with epoch_seconds while busy is low; the request is taken at
//   that edge and busy stays high until the result is out. The result
//   (year, month, day, hour, minute, second) is valid for exactly one cycle,
//   marked by done; the receiver cannot stall. Result ports are rewritten
//   while the next request is in progress.
// Sequence (start edge to done): the states QEST, QMUL and QSUB estimate
//   and remove whole 400-year cycles with one multiplier; then one shared
//   subtract/compare unit takes off, one per cycle, the leftover 400-year
//   cycles (0..2, always 0 at 32 bits), the whole years, months and days,
//   the hours and the minutes, plus one closing compare per stage.
// Throughput: one request at a time; a new one may start in the done cycle.
// Reset: rst (synchronous) returns the sequencer to idle; no results pending.
// ----------------------------------------------------------------------------
module epoch_to_calendar_datetime #(
  parameter int EPOCH_BITS = e2c_pkg::EPOCH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [EPOCH_BITS-1:0] epoch_seconds,
  output logic                  busy,
  output logic                  done,
  output logic [11:0]           year,
  output logic [3:0]            month,
  output logic [4:0]            day,
  output logic [4:0]            hour,
  output logic [5:0]            minute,
  output logic [5:0]            second
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QEST  = 4'd1;
  localparam logic [3:0] S_QMUL  = 4'd2;
  localparam logic [3:0] S_QSUB  = 4'd3;
  localparam logic [3:0] S_CYC   = 4'd4;
  localparam logic [3:0] S_YEAR  = 4'd5;
  localparam logic [3:0] S_MONTH = 4'd6;
  localparam logic [3:0] S_DAY   = 4'd7;
  localparam logic [3:0] S_HOUR  = 4'd8;
  localparam logic [3:0] S_MIN   = 4'd9;

  logic [3:0]    state;
  logic [63:0]   secs;
  logic [30:0]   cycles;
  logic [56:0]   prod;
  e2c_pkg::rem_t rem;
  logic [8:0]    ymod;

  logic [31:0]   mul_a;
  logic [30:0]   mul_b;
  logic [62:0]   mul_p;
  logic [63:0]   cyc_rem;
  e2c_pkg::rem_t sub_b;
  e2c_pkg::rem_t sub_diff;
  logic          sub_borrow;
  logic          leap;

  assign leap = e2c_pkg::is_leap(ymod);

  // cycle estimate from the upper word, then estimate times CYCLE_SECS / 128
  always_comb begin
    unique case (state)
      S_QEST: begin
        mul_a = secs[63:32];
        mul_b = e2c_pkg::CYCLE_RECIP;
      end
      S_QMUL: begin
        mul_a = {1'b0, cycles};
        mul_b = e2c_pkg::CYCLE_SECS_DIV128;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {31'd0, mul_a} * {32'd0, mul_b};

  // the estimate never exceeds the true cycle count
  assign cyc_rem = secs - {prod, 7'd0};

  always_comb begin
    unique case (state)
      S_CYC:   sub_b = e2c_pkg::CYCLE_SECS;
      S_YEAR:  sub_b = leap ? e2c_pkg::LEAP_YEAR_SECS : e2c_pkg::YEAR_SECS;
      S_MONTH: sub_b = e2c_pkg::month_secs(month, leap);
      S_DAY:   sub_b = e2c_pkg::DAY_SECS;
      S_HOUR:  sub_b = e2c_pkg::HOUR_SECS;
      S_MIN:   sub_b = e2c_pkg::MINUTE_SECS;
      default: sub_b = '0;
    endcase
  end

  e2c_sub u_sub (
    .a      (rem),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_MIN) && sub_borrow;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            secs  <= 64'(epoch_seconds);
            state <= S_QEST;
          end
        end
        S_QEST: begin
          cycles <= mul_p[62:32];
          state  <= S_QMUL;
        end
        S_QMUL: begin
          prod  <= mul_p[56:0];
          year  <= e2c_pkg::EPOCH_YEAR + 12'(cycles[11:0] * e2c_pkg::CYCLE_YEARS);
          ymod  <= e2c_pkg::EPOCH_YEAR_MOD400;
          state <= S_QSUB;
        end
        S_QSUB: begin
          rem   <= cyc_rem[e2c_pkg::REM_BITS-1:0];
          state <= S_CYC;
        end
        // estimate is short of the true 400-year count by at most two
        S_CYC: begin
          if (sub_borrow) begin
            state <= S_YEAR;
          end else begin
            rem  <= sub_diff;
            year <= year + e2c_pkg::CYCLE_YEARS;
          end
        end
        S_YEAR: begin
          if (sub_borrow) begin
            month <= 4'd1;
            state <= S_MONTH;
          end else begin
            rem  <= sub_diff;
            year <= year + 1'b1;
            ymod <= (ymod == 9'd399) ? 9'd0 : ymod + 1'b1;
          end
        end
        S_MONTH: begin
          if (sub_borrow) begin
            day   <= 5'd1;
            state <= S_DAY;
          end else begin
            rem   <= sub_diff;
            month <= month + 1'b1;
          end
        end
        S_DAY: begin
          if (sub_borrow) begin
            hour  <= 5'd0;
            state <= S_HOUR;
          end else begin
            rem <= sub_diff;
            day <= day + 1'b1;
          end
        end
        S_HOUR: begin
          if (sub_borrow) begin
            minute <= 6'd0;
            state  <= S_MIN;
          end else begin
            rem  <= sub_diff;
            hour <= hour + 1'b1;
          end
        end
        S_MIN: begin
          if (sub_borrow) begin
            second <= rem[5:0];
            state  <= S_IDLE;
          end else begin
            rem    <= sub_diff;
            minute <= minute + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks epoch_to_calendar_datetime against a behavioral calendar converter.
// A queue-fed driver sends requests through the start/busy handshake with
// random idle cycles. A clocked monitor compares each done strobe with the
// oldest predicted date and time. Directed boundary requests come first,
// followed by random requests biased toward day and hour boundaries.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM       = 600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  typedef struct {
    logic [31:0] secs;
    bit          drain;  // hold off until all results are back
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic        busy;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  request_t  pending_q[$];
  datetime_t expected_q[$];
  int        requests_taken = 0;
  int        error_count = 0;
  int        quiet_cycles = 0;

  // calendar corners: minute/hour/day rollover, leap days, 2038, 2100, top
  logic [31:0] edge_cases [25] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
    32'd94694399, 32'd94694400, 32'd951782400, 32'd978307199,
    32'd2147483647, 32'd2147483648,
    32'd4102444799, 32'd4102444800, 32'd4107542399, 32'd4107542400,
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
  };

  epoch_to_calendar_datetime uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .epoch_seconds (epoch_seconds),
    .busy          (busy),
    .done          (done),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  always #4 clk = ~clk;

  function automatic bit leap_year(input longint unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // month index 0..11
  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    if (m == 1)
      return leap ? 29 : 28;
    else if (m == 3 || m == 5 || m == 8 || m == 10)
      return 30;
    return 31;
  endfunction

  function automatic datetime_t civil_from_epoch(input logic [31:0] secs);
    longint unsigned t;
    longint unsigned days;
    longint unsigned yr;
    int unsigned     mon;
    datetime_t       r;
    t = {32'd0, secs};
    r.second = 6'(t % 60);
    t = t / 60;
    r.minute = 6'(t % 60);
    t = t / 60;
    r.hour = 5'(t % 24);
    days = t / 24;
    yr = 1970 + 400 * (days / 146097);
    days = days % 146097;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days = days - (leap_year(yr) ? 366 : 365);
      yr++;
    end
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, leap_year(yr))) begin
      days = days - days_in_month(mon, leap_year(yr));
      mon++;
    end
    r.year  = yr[11:0];
    r.month = 4'(mon + 1);
    r.day   = 5'(days + 1);
    return r;
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // idle now and then, except for a stretch of back-to-back requests
  function automatic bit sender_idle();
    if (requests_taken >= 200 && requests_taken < 320)
      return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_q.push_back(civil_from_epoch(epoch_seconds));
        requests_taken++;
      end
      if (pending_q.size() != 0 && !sender_idle() &&
          !(pending_q[0].drain && expected_q.size() != 0)) begin
        start         <= 1'b1;
        epoch_seconds <= pending_q[0].secs;
        void'(pending_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and watchdog counter
  always @(posedge clk) begin
    datetime_t got;
    datetime_t want;
    if (!rst) begin
      if (done) begin
        got = '{year, month, day, hour, minute, second};
        if (expected_q.size() == 0) begin
          log_error($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                              year, month, day, hour, minute, second));
        end else begin
          want = expected_q.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second)
            log_error($sformatf(
              "expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
              want.year, want.month, want.day, want.hour, want.minute, want.second,
              got.year, got.month, got.day, got.hour, got.minute, got.second));
        end
      end
      if (done || (start && !busy))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    request_t    req;
    int          i;
    int unsigned pick;
    foreach (edge_cases[k]) begin
      req.secs  = edge_cases[k];
      req.drain = 1'b0;
      pending_q.push_back(req);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        req.secs = $urandom;
      else if (pick < 8)
        req.secs = $urandom_range(0, 49709) * 86400 + ($urandom_range(0, 1) ? 0 : 86399);
      else
        req.secs = $urandom_range(0, 1193045) * 3600 + ($urandom_range(0, 1) ? 0 : 3599);
      req.drain = (i == 0 || i == 300);
      pending_q.push_back(req);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || start || expected_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_q.size() != 0)
      log_error($sformatf("%0d results never arrived", expected_q.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
